// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: payload structs, codes, sequencer states
// and the request/response structs of the shared divider.
// No dependencies.
`default_nettype none
package rau_pkg;

  // reduction datapath width: magnitudes stay below 2^63
  localparam int DW = 63;
  localparam int CW = $clog2(DW);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIVZ = 2'd1,
    STAT_DENZ = 2'd2
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] a_num;
    logic        [30:0] a_den;
    logic signed [31:0] b_num;
    logic        [30:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic        [62:0] res_den;
    status_t            status;
  } out_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [DW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_QN_START,
    ST_QN_WAIT,
    ST_QD_START,
    ST_QD_WAIT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/rau_mul.sv =====
// Registered 32x32 unsigned multiplier, shared by the cross-multiplication steps.
// Depends on nothing.
`default_nettype none
module rau_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // register the full product
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

// ===== hdl/rau_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, quotient and remainder.
// Depends on rau_pkg.
`default_nettype none
module rau_div (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  import rau_pkg::*;

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] divisor;
  logic [DW-1:0] quot;
  logic [DW-1:0] rem;
  logic          done;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  // shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem, quot[DW-1]};
    diff   = rem_sh - {1'b0, divisor};
    ge     = !diff[DW];
  end

  // control: run flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      quot    <= req.dividend;
      rem     <= '0;
    end else if (run) begin
      rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quot <= {quot[DW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: sequencer, cross-multiply and reduction datapath.
// For a zero denominator the done strobe comes in the cycle after accept; otherwise the item
// runs through the cross-multiply steps and the Euclid steps, then two divisions, all on the
// shared 63-bit bit-serial divider. Busy stays high through the done cycle, so the next item
// is taken in the cycle after the strobe; the receiver cannot stall. Synchronous reset returns
// to idle. Depends on rau_pkg, rau_mul, rau_div.
`default_nettype none
module rational_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rau_pkg::in_t  in_item,
  output logic          busy,
  output logic          done,
  output rau_pkg::out_t res
);
  import rau_pkg::*;

  state_t        state;
  state_t        state_next;
  in_t           item;
  logic [DW-1:0] t1;
  logic [DW-1:0] t2;
  logic [DW-1:0] rn;
  logic [DW-1:0] rd;
  logic          rneg;
  status_t       stat;
  logic [DW-1:0] gx;
  logic [DW-1:0] gy;

  logic          den_zero;
  logic          an_neg;
  logic          bn_neg;
  logic [31:0]   an;
  logic [31:0]   bn;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic [DW-1:0] comb_rn;
  logic [DW-1:0] comb_rd;
  logic          comb_neg;
  status_t       comb_stat;
  logic          s1;
  logic          s2;
  logic          t1_ge;
  logic [DW-1:0] diff;

  assign den_zero = (in_item.a_den == '0) || (in_item.b_den == '0);

  // split operand numerators into sign and magnitude
  always_comb begin
    an_neg = item.a_num[31];
    bn_neg = item.b_num[31];
    an     = an_neg ? (~item.a_num + 32'd1) : item.a_num;
    bn     = bn_neg ? (~item.b_num + 32'd1) : item.b_num;
  end

  // pick multiplier operands for each cross-multiply step
  always_comb begin
    mul_a = an;
    mul_b = {1'b0, item.b_den};
    case (state)
      ST_MUL0: begin
        mul_a = an;
        mul_b = (item.operation == OP_MUL) ? bn : {1'b0, item.b_den};
      end
      ST_MUL1: begin
        mul_a = {1'b0, item.a_den};
        mul_b = (item.operation == OP_MUL) ? {1'b0, item.b_den} : bn;
      end
      ST_MUL2: begin
        mul_a = {1'b0, item.a_den};
        mul_b = {1'b0, item.b_den};
      end
      default: begin
        mul_a = an;
        mul_b = {1'b0, item.b_den};
      end
    endcase
  end

  rau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // combine products into signed unreduced numerator over positive denominator
  always_comb begin
    s1    = an_neg && (t1 != '0);
    s2    = (item.operation == OP_SUB) ? !bn_neg : bn_neg;
    if (t2 == '0) begin
      s2 = 1'b0;
    end
    t1_ge = (t1 >= t2);
    diff  = t1_ge ? (t1 - t2) : (t2 - t1);
    comb_stat = STAT_OK;
    comb_rd   = t2;
    comb_rn   = t1;
    comb_neg  = an_neg ^ bn_neg;
    case (item.operation)
      OP_ADD, OP_SUB: begin
        comb_rd = prod[DW-1:0];
        if (s1 == s2) begin
          comb_rn  = t1 + t2;
          comb_neg = s1;
        end else begin
          comb_rn  = diff;
          comb_neg = t1_ge ? s1 : s2;
        end
      end
      OP_DIV: begin
        if (bn == '0) begin
          comb_rn   = DW'(an);
          comb_rd   = DW'(item.a_den);
          comb_neg  = an_neg && (an != '0);
          comb_stat = STAT_DIVZ;
        end
      end
      default: begin
        comb_rn  = t1;
        comb_rd  = t2;
        comb_neg = an_neg ^ bn_neg;
      end
    endcase
    if (comb_rn == '0) begin
      comb_neg = 1'b0;
    end
  end

  rau_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (start) state_next = den_zero ? ST_OUT : ST_MUL0;
      ST_MUL0:      state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_COMB;
      ST_COMB:      state_next = ST_GCD_START;
      ST_GCD_START: state_next = (gy == '0) ? ST_QN_START : ST_GCD_WAIT;
      ST_GCD_WAIT:  if (div_rsp.done) state_next = ST_GCD_START;
      ST_QN_START:  state_next = ST_QN_WAIT;
      ST_QN_WAIT:   if (div_rsp.done) state_next = ST_QD_START;
      ST_QD_START:  state_next = ST_QD_WAIT;
      ST_QD_WAIT:   if (div_rsp.done) state_next = ST_OUT;
      ST_OUT:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs and divider requests
  always_comb begin
    busy             = (state != ST_IDLE);
    done             = (state == ST_OUT);
    div_req.start    = 1'b0;
    div_req.dividend = gx;
    div_req.divisor  = gy;
    case (state)
      ST_GCD_START: div_req.start = (gy != '0);
      ST_QN_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = rn;
        div_req.divisor  = gx;
      end
      ST_QD_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = rd;
        div_req.divisor  = gx;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          item <= in_item;
          rn   <= '0;
          rd   <= DW'(1);
          rneg <= 1'b0;
          stat <= STAT_DENZ;
        end
      end
      ST_MUL1: t1 <= prod[DW-1:0];
      ST_MUL2: t2 <= prod[DW-1:0];
      ST_COMB: begin
        rn   <= comb_rn;
        rd   <= comb_rd;
        rneg <= comb_neg;
        stat <= comb_stat;
        gx   <= comb_rn;
        gy   <= comb_rd;
      end
      ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          gx <= gy;
          gy <= div_rsp.rem;
        end
      end
      ST_QN_WAIT: if (div_rsp.done) rn <= div_rsp.quot;
      ST_QD_WAIT: if (div_rsp.done) rd <= div_rsp.quot;
      default: ;
    endcase
  end

  // drive the result beat
  assign res.res_num = rneg ? (64'd0 - {1'b0, rn}) : {1'b0, rn};
  assign res.res_den = rd;
  assign res.status  = stat;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for rational_arithmetic_unit: directed table, then random fractions,
// every result beat checked field by field against the table or a built-in fraction reducer.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module tb_top;
  import rau_pkg::*;

  localparam int              NUM_RANDOM = 830;
  localparam int              TAIL_CYCLES = 20;
  localparam longint          TIMEOUT = 64'd400_000_000;
  localparam logic [30:0]     DEN_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0]     NUM_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]     NUM_MIN = 32'h8000_0000;
  localparam logic [63:0]     DEN_MAX_SQ = 64'd4611686014132420609;

  typedef struct {
    in_t  stim;
    bit   known;
    out_t want;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  start;
  in_t   in_item;
  logic  busy;
  logic  done;
  out_t  res;

  out_t     expected_q[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       checked = 0;
  int       divz_seen = 0;
  int       denz_seen = 0;
  int       op_count[4] = '{0, 0, 0, 0};
  int       burst_left = 0;

  rational_arithmetic_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .done    (done),
    .res     (res)
  );

  // free-running clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop if the block hangs
  initial begin
    #(TIMEOUT);
    $display("*** FAILED ***");
    $display("timeout at %0t: %0d result beats still expected", $time, expected_q.size());
    $finish;
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, got num %0d den %0d status %s",
                 $time, res.res_num, res.res_den, res.status.name());
      end else begin
        out_t want;
        want = expected_q.pop_front();
        checked++;
        if (want.status == STAT_DIVZ) divz_seen++;
        if (want.status == STAT_DENZ) denz_seen++;
        if (res.res_num !== want.res_num) begin
          mismatches++;
          $display("%0t: res_num expected %0d actual %0d", $time, want.res_num, res.res_num);
        end
        if (res.res_den !== want.res_den) begin
          mismatches++;
          $display("%0t: res_den expected %0d actual %0d", $time, want.res_den, res.res_den);
        end
        if (res.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %s actual %0d", $time, want.status.name(), res.status);
        end
      end
    end
  end

  // Cross-multiply, move the sign to the numerator, reduce by one gcd.
  function automatic out_t rational_result(in_t x);
    logic [63:0] an, bn, ad, bd, t1, t2, n, d, u, v, r;
    logic        an_neg, bn_neg, s1, s2, neg;
    status_t     st;
    out_t        y;
    an_neg = x.a_num[31];
    bn_neg = x.b_num[31];
    an = {{32{x.a_num[31]}}, x.a_num};
    bn = {{32{x.b_num[31]}}, x.b_num};
    if (an_neg) an = 64'd0 - an;
    if (bn_neg) bn = 64'd0 - bn;
    ad = {33'd0, x.a_den};
    bd = {33'd0, x.b_den};
    st = STAT_OK;
    // zero denominator wins over everything else
    if (ad == 64'd0 || bd == 64'd0) begin
      y.res_num = '0;
      y.res_den = 63'd1;
      y.status  = STAT_DENZ;
      return y;
    end
    case (x.operation)
      OP_ADD, OP_SUB: begin
        t1 = an * bd;
        t2 = ad * bn;
        s1 = an_neg && (t1 != 64'd0);
        s2 = (x.operation == OP_SUB) ? !bn_neg : bn_neg;
        if (t2 == 64'd0) s2 = 1'b0;
        if (s1 == s2) begin
          n = t1 + t2;
          neg = s1;
        end else if (t1 >= t2) begin
          n = t1 - t2;
          neg = s1;
        end else begin
          n = t2 - t1;
          neg = s2;
        end
        d = ad * bd;
      end
      OP_MUL: begin
        n = an * bn;
        neg = an_neg != bn_neg;
        d = ad * bd;
      end
      default: begin
        // divide by a zero fraction hands back the first operand, reduced
        if (bn == 64'd0) begin
          n = an;
          d = ad;
          neg = an_neg;
          st = STAT_DIVZ;
        end else begin
          n = an * bd;
          d = ad * bn;
          neg = an_neg != bn_neg;
        end
      end
    endcase
    if (n == 64'd0) neg = 1'b0;
    u = n;
    v = d;
    while (v != 64'd0) begin
      r = u % v;
      u = v;
      v = r;
    end
    n = n / u;
    d = d / u;
    y.res_num = neg ? (64'd0 - n) : n;
    y.res_den = d[62:0];
    y.status  = st;
    return y;
  endfunction

  // kind 0: full range, 1: small, 2: corner values
  function automatic logic [31:0] rand_num(int kind);
    logic [31:0] m;
    case (kind)
      0: rand_num = $urandom;
      1: begin
        m = $urandom_range(0, 1000);
        rand_num = $urandom_range(0, 1) ? (32'd0 - m) : m;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: rand_num = 32'd0;
          1: rand_num = 32'd1;
          2: rand_num = 32'hFFFF_FFFF;
          3: rand_num = NUM_MAX;
          4: rand_num = NUM_MIN;
          default: rand_num = NUM_MIN + 32'd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [30:0] rand_den(int kind);
    case (kind)
      0: rand_den = 31'($urandom_range(1, 32'h7FFF_FFFF));
      1: rand_den = 31'($urandom_range(1, 1000));
      default: begin
        case ($urandom_range(0, 3))
          0: rand_den = 31'd1;
          1: rand_den = 31'd2;
          2: rand_den = DEN_MAX;
          default: rand_den = 31'h4000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic in_t random_item();
    in_t x;
    int  ka, kb;
    ka = $urandom_range(0, 2);
    kb = $urandom_range(0, 2);
    x.operation = op_t'($urandom_range(0, 3));
    // lean on small operands so most reductions stay short
    if ($urandom_range(0, 9) < 4) begin
      ka = 1;
      kb = 1;
    end
    x.a_num = rand_num(ka);
    x.a_den = rand_den(ka);
    x.b_num = rand_num(kb);
    x.b_den = rand_den(kb);
    case ($urandom_range(0, 11))
      0: begin
        x.operation = OP_DIV;
        x.b_num = '0;
      end
      1: begin
        if ($urandom_range(0, 1)) x.a_den = '0;
        if ($urandom_range(0, 1)) x.b_den = '0;
        else if (x.a_den != '0) x.b_den = '0;
      end
      2: x.a_num = '0;
      default: ;
    endcase
    return x;
  endfunction

  function automatic void add_row(op_t op, logic [31:0] an, logic [30:0] ad,
                                  logic [31:0] bn, logic [30:0] bd, bit known,
                                  logic [63:0] rn, logic [62:0] rd, status_t st);
    dir_row_t row;
    row.stim.operation = op;
    row.stim.a_num = an;
    row.stim.a_den = ad;
    row.stim.b_num = bn;
    row.stim.b_den = bd;
    row.known = known;
    row.want.res_num = rn;
    row.want.res_den = rd;
    row.want.status = st;
    dir_rows.push_back(row);
  endfunction

  // Hold one beat until accepted, log its expectation, then idle per burst pattern.
  task automatic issue(input in_t x, input bit known, input out_t want);
    int pause;
    start <= 1'b1;
    in_item <= x;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_q.push_back(known ? want : rational_result(x));
    op_count[x.operation]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      pause = $urandom_range(1, 40);
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  initial begin
    out_t none;
    none = '0;
    rst <= 1'b1;
    start <= 1'b0;
    in_item <= '0;

    // plain cases of each operation, checked by the reducer
    add_row(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 0, '0, '0, STAT_OK);
    add_row(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd3, 0, '0, '0, STAT_OK);
    add_row(OP_MUL, 32'd2, 31'd3, 32'd3, 31'd4, 0, '0, '0, STAT_OK);
    add_row(OP_DIV, 32'd1, 31'd2, 32'd3, 31'd4, 0, '0, '0, STAT_OK);
    add_row(OP_ADD, -32'sd1, 31'd2, 32'd1, 31'd3, 0, '0, '0, STAT_OK);
    // zero operand denominators, including ahead of a zero divisor
    add_row(OP_ADD, 32'd5, 31'd0, 32'd1, 31'd3, 1, 64'd0, 63'd1, STAT_DENZ);
    add_row(OP_MUL, 32'd5, 31'd7, 32'd1, 31'd0, 1, 64'd0, 63'd1, STAT_DENZ);
    add_row(OP_DIV, 32'd5, 31'd0, 32'd0, 31'd0, 1, 64'd0, 63'd1, STAT_DENZ);
    // divide by a zero fraction
    add_row(OP_DIV, 32'd6, 31'd4, 32'd0, 31'd5, 1, 64'd3, 63'd2, STAT_DIVZ);
    add_row(OP_DIV, 32'd0, 31'd7, 32'd0, 31'd3, 1, 64'd0, 63'd1, STAT_DIVZ);
    add_row(OP_DIV, -32'sd6, 31'd4, 32'd0, 31'd1, 1, -64'sd3, 63'd2, STAT_DIVZ);
    // zero results
    add_row(OP_SUB, 32'd3, 31'd5, 32'd3, 31'd5, 1, 64'd0, 63'd1, STAT_OK);
    add_row(OP_MUL, 32'd0, 31'd9, -32'sd5, 31'd7, 1, 64'd0, 63'd1, STAT_OK);
    // field extremes
    add_row(OP_MUL, NUM_MIN, 31'd1, NUM_MIN, 31'd1, 1, 64'h4000_0000_0000_0000, 63'd1,
            STAT_OK);
    add_row(OP_ADD, NUM_MAX, 31'd1, NUM_MAX, 31'd1, 1, 64'd4294967294, 63'd1, STAT_OK);
    add_row(OP_SUB, NUM_MIN, 31'd1, NUM_MAX, 31'd1, 1, -64'sd4294967295, 63'd1, STAT_OK);
    add_row(OP_MUL, 32'd1, DEN_MAX, 32'd1, DEN_MAX, 1, 64'd1, DEN_MAX_SQ[62:0], STAT_OK);
    add_row(OP_DIV, NUM_MAX, 31'd1, 32'd1, DEN_MAX, 1, DEN_MAX_SQ, 63'd1, STAT_OK);
    add_row(OP_DIV, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX, 1, 64'd1, 63'd1, STAT_OK);
    add_row(OP_DIV, 32'd1, DEN_MAX, -32'sd1, 31'd1, 1, -64'sd1, 63'(DEN_MAX), STAT_OK);
    add_row(OP_MUL, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX, 1, 64'd1, 63'd1, STAT_OK);
    add_row(OP_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX - 31'd1, 0, '0, '0, STAT_OK);
    add_row(OP_SUB, NUM_MIN, 31'h4000_0000, NUM_MAX, DEN_MAX, 0, '0, '0, STAT_OK);
    add_row(OP_DIV, NUM_MIN, 31'd1, NUM_MAX, DEN_MAX, 0, '0, '0, STAT_OK);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (dir_rows[i]) issue(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);

    // random beats
    for (int i = 0; i < NUM_RANDOM; i++) issue(random_item(), 0, none);
    start <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d result beats: add %0d, sub %0d, mul %0d, div %0d",
             checked, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
    $display("divide by zero fraction %0d, zero denominator %0d, mismatches %0d",
             divz_seen, denz_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rau_pkg.sv
hdl/rau_mul.sv
hdl/rau_div.sv
hdl/rational_arithmetic_unit.sv
sim/tb_top.sv
